FILE: design/blc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blc_pkg
// Shared types and constants for the boundary loop checker.
// ----------------------------------------------------------------------------
package blc_pkg;

  localparam int VTX_W = 16;  // vertex id field width
  localparam int REF_W = 11;  // edge id field width

  typedef enum logic [1:0] {
    REQ_APPEND     = 2'd0,
    REQ_USE        = 2'd1,
    REQ_EMPTY_LOOP = 2'd2,
    REQ_EMPTY_FACE = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PENDING    = 3'd1,
    ST_EMPTY_FACE = 3'd2,
    ST_EMPTY_LOOP = 3'd3,
    ST_BAD_EDGE   = 3'd4,
    ST_OPEN_LOOP  = 3'd5,
    ST_BAD_VERTEX = 3'd6,
    ST_TABLE_FULL = 3'd7
  } status_t;

  // Configuration register byte addresses
  localparam logic [1:0] ADDR_VTX_LIMIT = 2'd0;

  typedef struct packed {
    req_type_t          req_type;
    logic [REF_W-1:0]   edge_ref;
    logic               orientation;
    logic [VTX_W-1:0]   first_vertex;
    logic [VTX_W-1:0]   second_vertex;
    logic               last_in_loop;
    logic               last_in_face;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic [REF_W-1:0]   new_edge_id;
    logic [VTX_W-1:0]   start_vertex;
    logic [VTX_W-1:0]   end_vertex;
    logic               face_done;
  } rsp_item_t;

endpackage

FILE: design/blc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module blc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read returns old data on a same-address write
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/boundary_loop_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_loop_checker
// Edge table plus streaming check of face boundary loops.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  req     | in        | req_valid/req_stall  | req_item_t (append, use, empty)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_item_t (one per request)
//  apb     | in/out    | psel/penable/pready  | vertex limit at address 0
//
//  One request per cycle while the result register drains; rsp_valid follows
//  the req transfer through the input register, then the result register.
//  The edge table is a RAM with registered read, so the lookup is issued
//  at the req transfer and its data is ready in the following cycle.
//  Synchronous reset clears the edge count and face state; the table itself
//  is not cleared since only entries below the edge count are ever used.
//  rsp_stall holds the result register; req_stall rises only when the
//  lookup stage is full and the result register cannot drain.
// ----------------------------------------------------------------------------
module boundary_loop_checker #(
  parameter int MAX_EDGES   = 1024,
  parameter int VERTEX_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  blc_pkg::req_item_t req,
  // result channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output blc_pkg::rsp_item_t rsp,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import blc_pkg::*;

  // stored vertex width: fields carry 16 bits, the table keeps the low bits
  localparam int VK     = (VERTEX_BITS < VTX_W) ? VERTEX_BITS : VTX_W;
  localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W  = $clog2(MAX_EDGES + 1);
  localparam int CMP_W  = (CNT_W > REF_W) ? CNT_W : REF_W;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [VTX_W-1:0] vtx_limit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_limit <= '0;
    end else if (psel && penable && pwrite && pready) begin
      // single register: every address in the window decodes to it
      vtx_limit <= pwdata[VTX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr)
      ADDR_VTX_LIMIT: prdata = 32'(vtx_limit);
      default:        prdata = 32'(vtx_limit);
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic      s1_valid;
  req_item_t s1_item;
  logic      out_free;
  logic      s1_adv;
  logic      req_xfer;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign s1_adv    = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;
  assign req_xfer  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      s1_item <= req;
    end
  end

  // --------------------------------------------------------------------------
  // Edge table: entry holds {second, first}
  // --------------------------------------------------------------------------
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_waddr;
  logic [2*VK-1:0]   tbl_wdata;
  logic [ADDR_W-1:0] tbl_raddr;
  logic [2*VK-1:0]   tbl_rdata;
  logic              fwd_hit;
  logic [2*VK-1:0]   fwd_data;
  logic [2*VK-1:0]   entry;
  logic [REF_W-1:0]  ref_minus1;

  assign ref_minus1 = req.edge_ref - REF_W'(1);
  assign tbl_raddr  = ADDR_W'(ref_minus1);

  blc_ram #(
    .WIDTH (2 * VK),
    .DEPTH (MAX_EDGES)
  ) u_edge_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (req_xfer),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // an append leaving the stage while the next use reads the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (req_xfer) begin
      fwd_hit <= tbl_we && (tbl_waddr == tbl_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      fwd_data <= tbl_wdata;
    end
  end

  assign entry = fwd_hit ? fwd_data : tbl_rdata;

  // --------------------------------------------------------------------------
  // Lookup stage: append bookkeeping and loop checks
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] edge_total, edge_total_next;
  logic [VK-1:0]    loop_start, loop_start_next;
  logic [VK-1:0]    prev_end, prev_end_next;
  logic             at_loop_start, at_loop_start_next;
  status_t          face_error, face_error_next;
  rsp_item_t        rsp_next;

  logic [VK-1:0]    v1, v2;
  logic [VK-1:0]    use_a, use_b, use_s, use_e, close_ref;
  logic             v1_ok, v2_ok, tbl_full, ref_bad;
  status_t          err;

  assign v1 = s1_item.first_vertex[VK-1:0];
  assign v2 = s1_item.second_vertex[VK-1:0];
  assign v1_ok = (v1 != '0) && (VTX_W'(v1) <= vtx_limit);
  assign v2_ok = (v2 != '0) && (VTX_W'(v2) <= vtx_limit);
  assign tbl_full = (edge_total >= CNT_W'(MAX_EDGES));
  assign ref_bad  = (s1_item.edge_ref == '0) ||
                    (CMP_W'(s1_item.edge_ref) > CMP_W'(edge_total));

  assign use_a = entry[VK-1:0];
  assign use_b = entry[2*VK-1:VK];
  assign use_s = s1_item.orientation ? use_b : use_a;
  assign use_e = s1_item.orientation ? use_a : use_b;
  // the loop start seen at close includes one set by this very use
  assign close_ref = at_loop_start ? use_s : loop_start;

  assign tbl_waddr = ADDR_W'(edge_total);
  assign tbl_wdata = {v2, v1};

  always_comb begin
    edge_total_next    = edge_total;
    loop_start_next    = loop_start;
    prev_end_next      = prev_end;
    at_loop_start_next = at_loop_start;
    face_error_next    = face_error;
    tbl_we             = 1'b0;
    err                = ST_OK;
    rsp_next.status       = ST_PENDING;
    rsp_next.new_edge_id  = '0;
    rsp_next.start_vertex = '0;
    rsp_next.end_vertex   = '0;
    rsp_next.face_done    = 1'b0;

    if (s1_item.req_type == REQ_APPEND) begin
      if (!v1_ok || !v2_ok) begin
        rsp_next.status = ST_BAD_VERTEX;
      end else if (tbl_full) begin
        rsp_next.status = ST_TABLE_FULL;
      end else begin
        tbl_we               = s1_adv;
        edge_total_next      = edge_total + CNT_W'(1);
        rsp_next.status      = ST_OK;
        rsp_next.new_edge_id = REF_W'(edge_total_next);
      end
    end else begin
      // latched error: skip evaluation until the face ends
      if (face_error == ST_OK) begin
        unique case (s1_item.req_type)
          REQ_USE: begin
            if (ref_bad) begin
              err = ST_BAD_EDGE;
            end else begin
              rsp_next.start_vertex = VTX_W'(use_s);
              rsp_next.end_vertex   = VTX_W'(use_e);
              if (at_loop_start) begin
                loop_start_next    = use_s;
                at_loop_start_next = 1'b0;
              end else if (prev_end != use_s) begin
                err = ST_OPEN_LOOP;
              end
              prev_end_next = use_e;
              if ((err == ST_OK) && (s1_item.last_in_loop || s1_item.last_in_face)) begin
                if (use_e != close_ref) begin
                  err = ST_OPEN_LOOP;
                end
                at_loop_start_next = 1'b1;
              end
            end
          end
          REQ_EMPTY_LOOP: err = at_loop_start ? ST_EMPTY_LOOP : ST_OPEN_LOOP;
          REQ_EMPTY_FACE: err = ST_EMPTY_FACE;
          default:        err = ST_OK;
        endcase
        face_error_next = err;
      end
      if (s1_item.last_in_face) begin
        rsp_next.status    = face_error_next;
        rsp_next.face_done = 1'b1;
        loop_start_next    = '0;
        prev_end_next      = '0;
        at_loop_start_next = 1'b1;
        face_error_next    = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total    <= '0;
      loop_start    <= '0;
      prev_end      <= '0;
      at_loop_start <= 1'b1;
      face_error    <= ST_OK;
    end else if (s1_adv) begin
      edge_total    <= edge_total_next;
      loop_start    <= loop_start_next;
      prev_end      <= prev_end_next;
      at_loop_start <= at_loop_start_next;
      face_error    <= face_error_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_append_count: assert property (@(posedge clk) disable iff (rst)
    tbl_we |=> (edge_total == $past(edge_total) + CNT_W'(1)))
    else $error("edge count did not step on a stored append");

  a_verdict_final: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.face_done) |-> (rsp.status != ST_PENDING))
    else $error("face verdict reported as pending");

  a_face_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && (s1_item.req_type != REQ_APPEND) && s1_item.last_in_face) |=>
      (at_loop_start && (face_error == ST_OK)))
    else $error("face state not cleared after verdict");

  a_new_id_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.new_edge_id != '0)) |-> ((rsp.status == ST_OK) && !rsp.face_done))
    else $error("edge id given on a rejected append or face item");

endmodule
